// ===== src/gar_pkg.sv =====
// ----------------------------------------------------------------------------
// gar_pkg: shared types, constants and helpers
// Queue item layout, register indexes, reciprocal constants and the rounding
// and clamping helpers used by the front and back of the actuator core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gar_pkg;

	// Stream widths
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 112;

	// Configuration register indexes
	localparam logic [1:0] CFG_PWM_PERIOD = 2'd0;
	localparam logic [1:0] CFG_P_GAIN     = 2'd1;
	localparam logic [1:0] CFG_TIME_STEP  = 2'd2;

	// Register reset values
	localparam logic [14:0] PWM_PERIOD_RST = 15'd1842;
	localparam logic [11:0] P_GAIN_RST     = 12'd256;
	localparam logic [7:0]  TIME_STEP_RST  = 8'd77;

	// floor(2^40 / 10000) and floor(2^36 / 1000) for duty scaling
	localparam logic [26:0] RECIP_10000 = 27'd109951162;
	localparam logic [26:0] RECIP_1000  = 27'd68719476;

	// Classified item carried from the front to the back
	typedef struct packed {
		logic               tmo;    // timeout event
		logic signed [14:0] rpm_p;  // saturated propeller rpm
		logic signed [18:0] t2;     // battery target, Q.9, unclamped
		logic        [15:0] tgt_b;  // battery target clamped to 0..51200
		logic signed [15:0] rud;    // rudder target, unclamped
		logic signed [15:0] tgt_r;  // rudder target clamped to +-30 deg
	} gar_item_t;

	// Arithmetic shift right, rounding to nearest, halves away from zero
	function automatic logic signed [47:0] rnd_shr(input logic signed [47:0] v,
			input int unsigned sh);
		logic signed [47:0] half;
		half = 48'sd1 <<< (sh - 1);
		return (v + half - $signed({47'd0, v[47]})) >>> sh;
	endfunction

	function automatic logic signed [47:0] clamp_s48(input logic signed [47:0] v,
			input logic signed [47:0] lo, input logic signed [47:0] hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

endpackage

`default_nettype wire

// ===== src/gar_front.sv =====
// ----------------------------------------------------------------------------
// gar_front: input classifier
// Takes stream transactions, computes the propeller rpm and the clamped
// battery and rudder targets, and pushes one item into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gar_front (
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [gar_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // ref_speed, ref_pitch, ref_rudder
	input  wire logic [0:0]                      s_axis_tuser,  // command
	input  wire logic                            q_full,
	output logic                                 q_push,
	output gar_pkg::gar_item_t                   q_item
);
	import gar_pkg::*;

	logic signed [15:0] speed;
	logic signed [15:0] pitch;
	logic signed [15:0] rudder;
	logic signed [29:0] speed_x;
	logic signed [29:0] speed_prod;
	logic signed [47:0] rpm_p_w;
	logic signed [18:0] t2;

	// Handshake: accept while the queue has room
	assign s_axis_tready = !q_full;
	assign q_push        = s_axis_tvalid && !q_full;

	// Field extraction and classification
	always_comb begin
		speed      = $signed(s_axis_tdata[15:0]);
		pitch      = $signed(s_axis_tdata[31:16]);
		rudder     = $signed(s_axis_tdata[47:32]);
		speed_x    = 30'(speed);
		speed_prod = speed_x * 30'sd5000;
		rpm_p_w    = clamp_s48(rnd_shr(48'(speed_prod), 8), -48'sd10000, 48'sd10000);
		t2         = (19'(pitch) + 19'sd5120) * 19'sd5;

		q_item.tmo   = s_axis_tuser[0];
		q_item.rpm_p = rpm_p_w[14:0];
		q_item.t2    = t2;
		q_item.rud   = rudder;
		priority if (t2 < 19'sd0)
			q_item.tgt_b = 16'd0;
		else if (t2 > 19'sd51200)
			q_item.tgt_b = 16'd51200;
		else
			q_item.tgt_b = t2[15:0];
		priority if (rudder < -16'sd7680)
			q_item.tgt_r = -16'sd7680;
		else if (rudder > 16'sd7680)
			q_item.tgt_r = 16'sd7680;
		else
			q_item.tgt_r = rudder;
	end

endmodule

`default_nettype wire

// ===== src/gar_fifo.sv =====
// ----------------------------------------------------------------------------
// gar_fifo: item queue
// Small register queue between the classifier and the control sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gar_fifo #(
	parameter int DEPTH = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire gar_pkg::gar_item_t wr_item,
	input  wire logic               pop,
	output gar_pkg::gar_item_t      rd_item,
	output logic                    full,
	output logic                    empty
);
	import gar_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	gar_item_t       queue_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_item = queue_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push)
			queue_q[wr_ptr_q] <= wr_item;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			unique case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/gar_back.sv =====
// ----------------------------------------------------------------------------
// gar_back: control sequencer
// Runs the proportional step on the battery and rudder axes, keeps the
// estimates and last rpms, scales the three duties and drives the output
// register. Also holds the configuration registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gar_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic [14:0]                     cfg_data,
	input  wire logic                            q_empty,
	input  wire gar_pkg::gar_item_t              q_item,
	output logic                                 q_pop,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// rpm_propeller, rpm_battery, rpm_rudder_motor, duty_propeller, duty_battery,
	// duty_rudder, battery_position, rudder_angle, one zero pad bit
	output logic [gar_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	output logic [0:0]                           m_axis_tuser   // timed_out
);
	import gar_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_GAIN, ST_STEP, ST_EST, ST_DMUL, ST_DREC, ST_DOUT
	} state_t;

	state_t state_q;

	// Configuration
	logic [14:0] pwm_period_q;
	logic [11:0] p_gain_q;
	logic [7:0]  time_step_q;

	// Controller state
	logic signed [15:0] be_q;
	logic signed [15:0] re_q;
	logic signed [14:0] rpm_p_q;
	logic signed [7:0]  rpm_b_q;
	logic signed [7:0]  rpm_r_q;

	// Item and datapath registers
	logic               tmo_q;
	logic signed [18:0] t2_q;
	logic        [15:0] tgb_q;
	logic signed [15:0] rud_q;
	logic signed [15:0] tgr_q;
	logic               en_b_q;
	logic               en_r_q;
	logic signed [30:0] act_b_q;
	logic signed [29:0] act_r_q;
	logic signed [39:0] stp_b_q;
	logic signed [38:0] stp_r_q;
	logic        [29:0] x_p_q;
	logic        [25:0] x_b_q;
	logic        [25:0] x_r_q;
	logic        [15:0] q0_p_q;
	logic        [15:0] q0_b_q;
	logic        [15:0] q0_r_q;

	logic                   m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;
	logic                   m_user_q;

	// Combinational datapath
	logic signed [17:0] e_b;
	logic signed [16:0] e_r;
	logic               en_b;
	logic               en_r;
	logic signed [30:0] act_b_n;
	logic signed [29:0] act_r_n;
	logic signed [39:0] stp_b_n;
	logic signed [38:0] stp_r_n;
	logic signed [47:0] rpm_b_w;
	logic signed [47:0] n_r;
	logic signed [47:0] mag_r;
	logic signed [47:0] sum_r;
	logic        [13:0] m_r;
	logic        [18:0] third_r;
	logic        [6:0]  mag7_r;
	logic signed [7:0]  rpm_r_n;
	logic signed [47:0] be_w;
	logic signed [47:0] re_w;
	logic        [15:0] two_p;
	logic        [13:0] c_p;
	logic signed [11:0] r10_b;
	logic signed [11:0] r10_r;
	logic        [9:0]  c_b;
	logic        [9:0]  c_r;
	logic        [29:0] x_p_n;
	logic        [25:0] x_b_n;
	logic        [25:0] x_r_n;
	logic        [56:0] prod_p;
	logic        [52:0] prod_b;
	logic        [52:0] prod_r;
	logic        [29:0] rem_p;
	logic        [25:0] rem_b;
	logic        [25:0] rem_r;
	logic        [15:0] half_duty;
	logic        [15:0] duty_p;
	logic        [15:0] duty_b;
	logic        [15:0] duty_r;
	logic               out_free;

	assign cfg_ready     = 1'b1;
	assign q_pop         = (state_q == ST_IDLE) && !q_empty;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_period_q <= PWM_PERIOD_RST;
			p_gain_q     <= P_GAIN_RST;
			time_step_q  <= TIME_STEP_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PWM_PERIOD: pwm_period_q <= cfg_data;
				CFG_P_GAIN:     p_gain_q     <= cfg_data[11:0];
				CFG_TIME_STEP:  time_step_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Gain and step products, rpm rounding, estimate update
	always_comb begin
		e_b     = $signed({2'b00, tgb_q}) - 18'($signed({be_q, 1'b0}));
		e_r     = 17'(tgr_q) - 17'(re_q);
		en_b    = (t2_q != 19'($signed({be_q, 1'b0})));
		en_r    = (rud_q != re_q);
		act_b_n = 31'(e_b) * $signed({19'd0, p_gain_q});
		act_r_n = 30'(e_r) * $signed({18'd0, p_gain_q});
		stp_b_n = 40'(act_b_q) * $signed({32'd0, time_step_q});
		stp_r_n = 39'(act_r_q) * $signed({31'd0, time_step_q});

		// battery rpm: action / 2^17
		rpm_b_w = clamp_s48(rnd_shr(48'(act_b_q), 17), -48'sd100, 48'sd100);

		// rudder rpm: (action + 30) * 5 / 3, action in Q.16
		n_r     = (48'(act_r_q) + 48'sd1966080) * 48'sd5;
		mag_r   = n_r[47] ? -n_r : n_r;
		sum_r   = mag_r + 48'sd98304;
		m_r     = sum_r[29:16];
		third_r = 19'(m_r[8:0]) * 19'd683;
		mag7_r  = (m_r >= 14'd300) ? 7'd100 : third_r[17:11];
		rpm_r_n = n_r[47] ? -$signed({1'b0, mag7_r}) : $signed({1'b0, mag7_r});

		be_w = clamp_s48(48'(be_q) + rnd_shr(48'(stp_b_q), 17), -48'sd32768, 48'sd32767);
		re_w = clamp_s48(48'(re_q) + rnd_shr(48'(stp_r_q), 16), -48'sd32768, 48'sd32767);
	end

	// Duty scaling: clamp, times twice the period, times the reciprocal to divide
	always_comb begin
		two_p = {pwm_period_q, 1'b0};
		priority if (rpm_p_q < 15'sd450)
			c_p = 14'd450;
		else if (rpm_p_q > 15'sd9500)
			c_p = 14'd9500;
		else
			c_p = rpm_p_q[13:0];
		r10_b = 12'(rpm_b_q) * 12'sd10;
		r10_r = 12'(rpm_r_q) * 12'sd10;
		priority if (r10_b < 12'sd45)
			c_b = 10'd45;
		else if (r10_b > 12'sd950)
			c_b = 10'd950;
		else
			c_b = r10_b[9:0];
		priority if (r10_r < 12'sd45)
			c_r = 10'd45;
		else if (r10_r > 12'sd950)
			c_r = 10'd950;
		else
			c_r = r10_r[9:0];
		x_p_n = 30'(c_p) * 30'(two_p);
		x_b_n = 26'(c_b) * 26'(two_p);
		x_r_n = 26'(c_r) * 26'(two_p);

		prod_p = 57'(x_p_q) * 57'(RECIP_10000);
		prod_b = 53'(x_b_q) * 53'(RECIP_1000);
		prod_r = 53'(x_r_q) * 53'(RECIP_1000);

		// quotient estimate is exact or one low
		rem_p = x_p_q - 30'(q0_p_q) * 30'd10000;
		rem_b = x_b_q - 26'(q0_b_q) * 26'd1000;
		rem_r = x_r_q - 26'(q0_r_q) * 26'd1000;

		half_duty = {1'b0, pwm_period_q};
		duty_p = (tmo_q || rpm_p_q == '0) ? half_duty
			: q0_p_q + {15'd0, (rem_p >= 30'd10000)};
		duty_b = (tmo_q || rpm_b_q == '0) ? half_duty
			: q0_b_q + {15'd0, (rem_b >= 26'd1000)};
		duty_r = (tmo_q || rpm_r_q == '0) ? half_duty
			: q0_r_q + {15'd0, (rem_r >= 26'd1000)};
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					tmo_q <= q_item.tmo;
					t2_q  <= q_item.t2;
					tgb_q <= q_item.tgt_b;
					rud_q <= q_item.rud;
					tgr_q <= q_item.tgt_r;
				end
			end
			ST_GAIN: begin
				en_b_q  <= en_b;
				en_r_q  <= en_r;
				act_b_q <= act_b_n;
				act_r_q <= act_r_n;
			end
			ST_STEP: begin
				stp_b_q <= stp_b_n;
				stp_r_q <= stp_r_n;
			end
			ST_DMUL: begin
				x_p_q <= x_p_n;
				x_b_q <= x_b_n;
				x_r_q <= x_r_n;
			end
			ST_DREC: begin
				q0_p_q <= prod_p[55:40];
				q0_b_q <= prod_b[51:36];
				q0_r_q <= prod_r[51:36];
			end
			default: ;
		endcase
	end

	// Sequencer, controller state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			be_q      <= '0;
			re_q      <= '0;
			rpm_p_q   <= '0;
			rpm_b_q   <= '0;
			rpm_r_q   <= '0;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
			m_user_q  <= 1'b0;
		end else begin
			// held result taken and no new one loading this cycle
			if (m_valid_q && m_axis_tready && (state_q != ST_DOUT))
				m_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						if (q_item.tmo) begin
							state_q <= ST_DOUT;
						end else begin
							rpm_p_q <= q_item.rpm_p;
							state_q <= ST_GAIN;
						end
					end
				end
				ST_GAIN: state_q <= ST_STEP;
				ST_STEP: begin
					if (en_b_q)
						rpm_b_q <= rpm_b_w[7:0];
					if (en_r_q)
						rpm_r_q <= rpm_r_n;
					state_q <= ST_EST;
				end
				ST_EST: begin
					if (en_b_q)
						be_q <= be_w[15:0];
					if (en_r_q)
						re_q <= re_w[15:0];
					state_q <= ST_DMUL;
				end
				ST_DMUL: state_q <= ST_DREC;
				ST_DREC: state_q <= ST_DOUT;
				ST_DOUT: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {1'b0, re_q, be_q, duty_r, duty_b, duty_p,
							rpm_r_q, rpm_b_q, rpm_p_q};
						m_user_q  <= tmo_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/glider_actuator_reference_to_pwm_core.sv =====
// ----------------------------------------------------------------------------
// glider_actuator_reference_to_pwm_core: glider actuator reference to PWM
// Turns speed, pitch and rudder references into motor rpms, position
// estimates and PWM compare values; forces 50% duty on a timeout event.
// ----------------------------------------------------------------------------
// A reference (tuser 0) goes through the control sequencer: taking it from
// the queue, gain products, step products with rpm rounding, estimate update,
// duty multiply, reciprocal scaling and the output load, which waits while a
// held result is not taken. A timeout event (tuser 1) goes from the queue
// straight to the output load. The sequencer works on one item at a time and
// takes no new one before the last is loaded; the front classifies and queues
// up to QUEUE_DEPTH items while the sequencer or the output side is busy, and
// the output register lets the next item start while a result waits to be
// taken. Configuration writes are always ready and take effect at once.
`timescale 1ns / 1ps
`default_nettype none

module glider_actuator_reference_to_pwm_core #(
	parameter int QUEUE_DEPTH = 2   // 2..16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic [14:0]                     cfg_data,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [gar_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // ref_speed, ref_pitch, ref_rudder
	input  wire logic [0:0]                      s_axis_tuser,  // command
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// rpm_propeller, rpm_battery, rpm_rudder_motor, duty_propeller, duty_battery,
	// duty_rudder, battery_position, rudder_angle, one zero pad bit
	output logic [gar_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	output logic [0:0]                           m_axis_tuser   // timed_out
);
	import gar_pkg::*;

	gar_item_t push_item;
	gar_item_t head_item;
	logic      q_push;
	logic      q_pop;
	logic      q_full;
	logic      q_empty;

	// Classifier
	gar_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (push_item)
	);

	// Item queue
	gar_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_item (push_item),
		.pop     (q_pop),
		.rd_item (head_item),
		.full    (q_full),
		.empty   (q_empty)
	);

	// Control sequencer
	gar_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.q_empty       (q_empty),
		.q_item        (head_item),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Checks
	a_queue_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("queue reports full and empty at once");

	a_timeout_duty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
			(m_axis_tdata[46:31] == m_axis_tdata[62:47]) &&
			(m_axis_tdata[62:47] == m_axis_tdata[78:63]))
		else $error("timeout result with unequal duties");

	a_rpm_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			($signed(m_axis_tdata[14:0]) <= 15'sd10000) &&
			($signed(m_axis_tdata[14:0]) >= -15'sd10000) &&
			($signed(m_axis_tdata[22:15]) <= 8'sd100) &&
			($signed(m_axis_tdata[22:15]) >= -8'sd100))
		else $error("rpm outside its saturation range");

endmodule

`default_nettype wire

// ===== sim/glider_actuator_reference_to_pwm_core_test.sv =====
// ----------------------------------------------------------------------------
// glider_actuator_reference_to_pwm_core_test: actuator core self-check bench
// Drives references and timeout events through the input stream and compares
// every result with a cycle-free model of the controller kept in step with the
// register settings, or with the table for typed rows. A short table of corner
// cases comes first. Random traffic follows under several register settings,
// including the extremes, with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glider_actuator_reference_to_pwm_core_test;

	import gar_pkg::*;

	localparam logic CMD_REFERENCE = 1'b0;
	localparam logic CMD_TIMEOUT   = 1'b1;

	localparam int PHASES           = 8;
	localparam int RANDOM_PER_PHASE = 240;
	localparam int DIRECTED_ROWS    = 18;
	localparam int DRAIN_CYCLES     = 24;
	localparam int WATCHDOG_LIMIT   = 2000;

	// One result transaction; order matches {tuser, tdata[110:0]}
	typedef struct packed {
		logic               timed_out;
		logic signed [15:0] rudder_angle;
		logic signed [15:0] battery_position;
		logic        [15:0] duty_rudder;
		logic        [15:0] duty_battery;
		logic        [15:0] duty_propeller;
		logic signed [7:0]  rpm_rudder;
		logic signed [7:0]  rpm_battery;
		logic signed [14:0] rpm_propeller;
	} pwm_result_t;

	// Directed table row; result is used only where typed is set
	typedef struct packed {
		logic               cmd;
		logic signed [15:0] speed;
		logic signed [15:0] pitch;
		logic signed [15:0] rudder;
		logic               typed;
		pwm_result_t        result;
	} stim_row_t;

	logic clk;
	logic arst_n = 1'b0;

	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [14:0] cfg_data  = '0;

	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // ref_speed, ref_pitch, ref_rudder
	logic [0:0]             s_axis_tuser  = '0;   // command
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;         // rpms, duties, estimates, pad bit
	logic [0:0]             m_axis_tuser;         // timed_out

	glider_actuator_reference_to_pwm_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Controller model: register copies and state
	longint period_q  = 1842;
	longint gain_q    = 256;
	longint step_q    = 77;
	logic   in_timeout = 1'b0;
	longint est_battery = 0;
	longint est_rudder  = 0;
	longint rpm_prop_q  = 0;
	longint rpm_batt_q  = 0;
	longint rpm_rud_q   = 0;

	pwm_result_t pwm_results_due[$];
	int          fault_count = 0;
	int          burst_left  = 0;
	stim_row_t   directed_rows [DIRECTED_ROWS];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_fault(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		fault_count++;
	endtask

	// Nearest, halves away from zero; d > 0
	function automatic longint div_round(input longint n, input longint d);
		if (n >= 0)
			return (n + d / 2) / d;
		return -((-n + d / 2) / d);
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Compare value for one motor; zero rpm means half duty
	function automatic longint compare_value(input longint rpm, input longint scale,
			input longint lo, input longint hi, input longint den);
		if (rpm == 0)
			return period_q;
		return (clip(rpm * scale, lo, hi) * 2 * period_q) / den;
	endfunction

	// Advance the controller model by one accepted item
	function automatic pwm_result_t actuator_update(input logic cmd,
			input logic signed [15:0] spd, input logic signed [15:0] pit,
			input logic signed [15:0] rud);
		pwm_result_t r;
		longint      t2;
		longint      err;
		longint      act;
		if (cmd == CMD_TIMEOUT) begin
			in_timeout = 1'b1;
			r.duty_propeller = period_q;
			r.duty_battery   = period_q;
			r.duty_rudder    = period_q;
		end else begin
			in_timeout = 1'b0;
			rpm_prop_q = clip(div_round(longint'(spd) * 5000, 256), -10000, 10000);
			// battery mover, target in Q.9
			t2 = (longint'(pit) + 5120) * 5;
			if (t2 != 2 * est_battery) begin
				err = clip(t2, 0, 51200) - 2 * est_battery;
				act = err * gain_q;
				rpm_batt_q = clip(div_round(act, 131072), -100, 100);
				est_battery = clip(est_battery + div_round(act * step_q, 131072),
					-32768, 32767);
			end
			// rudder, target in Q8.8
			if (longint'(rud) != est_rudder) begin
				err = clip(longint'(rud), -7680, 7680) - est_rudder;
				act = err * gain_q;
				rpm_rud_q = clip(div_round((act + 30 * 65536) * 5, 3 * 65536), -100, 100);
				est_rudder = clip(est_rudder + div_round(act * step_q, 65536), -32768, 32767);
			end
			r.duty_propeller = compare_value(rpm_prop_q, 1, 450, 9500, 10000);
			r.duty_battery   = compare_value(rpm_batt_q, 10, 45, 950, 1000);
			r.duty_rudder    = compare_value(rpm_rud_q, 10, 45, 950, 1000);
		end
		r.timed_out        = in_timeout;
		r.rpm_propeller    = rpm_prop_q;
		r.rpm_battery      = rpm_batt_q;
		r.rpm_rudder       = rpm_rud_q;
		r.battery_position = est_battery;
		r.rudder_angle     = est_rudder;
		return r;
	endfunction

	// Register write; only issued while the core is idle
	task automatic write_register(input logic [1:0] idx, input logic [14:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_PWM_PERIOD: period_q = val;
			CFG_P_GAIN:     gain_q   = val[11:0];
			CFG_TIME_STEP:  step_q   = val[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Input transaction with bursty pacing; model advances on acceptance
	task automatic send_item(input logic cmd, input logic signed [15:0] spd,
			input logic signed [15:0] pit, input logic signed [15:0] rud,
			input logic typed, input pwm_result_t fixed);
		pwm_result_t predicted;
		int          gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {rud, pit, spd};
		do @(posedge clk); while (!s_axis_tready);
		predicted = actuator_update(cmd, spd, pit, rud);
		pwm_results_due.push_back(typed ? fixed : predicted);
	endtask

	// Wait until every result is back, then let the pipeline settle
	task automatic drain_results();
		while (pwm_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Output side: ready pattern switches between free, random and long stalls
	initial begin : output_pacing
		int   seg_left;
		int   mode;
		int   hold;
		logic rdy;
		seg_left = 0;
		mode     = 0;
		hold     = 0;
		rdy      = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (seg_left == 0) begin
				mode     = $urandom_range(0, 2);
				seg_left = $urandom_range(50, 300);
			end
			seg_left--;
			case (mode)
				0: rdy = 1'b1;
				1: rdy = $urandom_range(0, 1);
				default: begin
					if (hold == 0) begin
						rdy  = ~rdy;
						hold = rdy ? $urandom_range(1, 4) : $urandom_range(1, 20);
					end
					hold--;
				end
			endcase
			m_axis_tready <= rdy;
		end
	end

	// Result check against the oldest expectation
	always @(posedge clk) begin : result_check
		pwm_result_t got;
		pwm_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tuser[0], m_axis_tdata[110:0]};
			if (m_axis_tdata[111] !== 1'b0)
				report_fault("tdata pad bit not zero");
			if (pwm_results_due.size() == 0) begin
				report_fault("result transaction with nothing expected");
			end else begin
				want = pwm_results_due.pop_front();
				if (got.rpm_propeller !== want.rpm_propeller)
					report_fault($sformatf("rpm_propeller got %0d expected %0d",
						got.rpm_propeller, want.rpm_propeller));
				if (got.rpm_battery !== want.rpm_battery)
					report_fault($sformatf("rpm_battery got %0d expected %0d",
						got.rpm_battery, want.rpm_battery));
				if (got.rpm_rudder !== want.rpm_rudder)
					report_fault($sformatf("rpm_rudder_motor got %0d expected %0d",
						got.rpm_rudder, want.rpm_rudder));
				if (got.duty_propeller !== want.duty_propeller)
					report_fault($sformatf("duty_propeller got %0d expected %0d",
						got.duty_propeller, want.duty_propeller));
				if (got.duty_battery !== want.duty_battery)
					report_fault($sformatf("duty_battery got %0d expected %0d",
						got.duty_battery, want.duty_battery));
				if (got.duty_rudder !== want.duty_rudder)
					report_fault($sformatf("duty_rudder got %0d expected %0d",
						got.duty_rudder, want.duty_rudder));
				if (got.battery_position !== want.battery_position)
					report_fault($sformatf("battery_position got %0d expected %0d",
						got.battery_position, want.battery_position));
				if (got.rudder_angle !== want.rudder_angle)
					report_fault($sformatf("rudder_angle got %0d expected %0d",
						got.rudder_angle, want.rudder_angle));
				if (got.timed_out !== want.timed_out)
					report_fault($sformatf("timed_out got %0d expected %0d",
						got.timed_out, want.timed_out));
			end
		end
	end

	// Watchdog: quiet cycles on every channel
	always @(posedge clk) begin : watchdog
		int quiet;
		if (!arst_n) begin
			quiet = 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", quiet);
				$display("[glider_actuator_reference_to_pwm_core] ERROR");
				$finish;
			end
		end
	end

	// Stimulus
	initial begin : stimulus
		int                 phase_period [PHASES];
		int                 phase_gain   [PHASES];
		int                 phase_step   [PHASES];
		logic               cmd;
		logic signed [15:0] spd;
		logic signed [15:0] pit;
		logic signed [15:0] rud;
		logic signed [15:0] corner [6];

		phase_period = '{0, 32767, 1, 0, -1, 1000, -1, 1842};
		phase_gain   = '{0, 4095, 0, 1, -1, 512, -1, 256};
		phase_step   = '{0, 255, 0, 1, -1, 26, -1, 77};
		corner = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd5120, -16'sd5120};

		// Corner cases; typed rows hold results read straight off the spec
		directed_rows = '{
			// timeout straight after reset: all zero, half duty
			'{CMD_TIMEOUT, 16'sd0, 16'sd0, 16'sd0, 1'b1,
				'{1'b1, 16'sd0, 16'sd0, 16'd1842, 16'd1842, 16'd1842, 8'sd0, 8'sd0, 15'sd0}},
			// both axes already at target, zero speed
			'{CMD_REFERENCE, 16'sd0, -16'sd5120, 16'sd0, 1'b1,
				'{1'b0, 16'sd0, 16'sd0, 16'd1842, 16'd1842, 16'd1842, 8'sd0, 8'sd0, 15'sd0}},
			// propeller saturates high, duty clamps to 95%
			'{CMD_REFERENCE, 16'sd32767, -16'sd5120, 16'sd0, 1'b1,
				'{1'b0, 16'sd0, 16'sd0, 16'd1842, 16'd1842, 16'd3499, 8'sd0, 8'sd0,
				15'sd10000}},
			// propeller saturates low, duty clamps to 4.5%
			'{CMD_REFERENCE, -16'sd32768, -16'sd5120, 16'sd0, 1'b1,
				'{1'b0, 16'sd0, 16'sd0, 16'd1842, 16'd1842, 16'd165, 8'sd0, 8'sd0,
				-15'sd10000}},
			// rpm rounding on exact halves
			'{CMD_REFERENCE, 16'sd16, -16'sd5120, 16'sd0, 1'b0, '0},
			'{CMD_REFERENCE, -16'sd16, -16'sd5120, 16'sd0, 1'b0, '0},
			// targets on and beyond the clamp limits
			'{CMD_REFERENCE, 16'sd1, 16'sd5120, 16'sd7680, 1'b0, '0},
			'{CMD_REFERENCE, 16'sd0, 16'sd32767, 16'sd32767, 1'b0, '0},
			'{CMD_REFERENCE, 16'sd0, -16'sd32768, -16'sd32768, 1'b0, '0},
			// timeout, then a repeated timeout
			'{CMD_TIMEOUT, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
			'{CMD_TIMEOUT, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
			'{CMD_REFERENCE, 16'sd256, 16'sd0, -16'sd7680, 1'b0, '0},
			'{CMD_REFERENCE, -16'sd256, 16'sd1280, 16'sd1, 1'b0, '0},
			'{CMD_REFERENCE, 16'sd32767, 16'sd32767, -16'sd1, 1'b0, '0},
			'{CMD_REFERENCE, -16'sd1, -16'sd1, -16'sd1, 1'b0, '0},
			// alternating bit patterns
			'{CMD_REFERENCE, 16'sh5555, 16'shAAAA, 16'sh5555, 1'b0, '0},
			'{CMD_REFERENCE, 16'shAAAA, 16'sh5555, 16'shAAAA, 1'b0, '0},
			// timeout carrying nonzero data
			'{CMD_TIMEOUT, 16'sh7FFF, 16'sh8000, 16'shFFFF, 1'b0, '0}
		};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				write_register(CFG_PWM_PERIOD, (phase_period[p] < 0) ?
					15'($urandom_range(1, 32767)) : 15'(phase_period[p]));
				write_register(CFG_P_GAIN, (phase_gain[p] < 0) ?
					15'($urandom_range(0, 32767)) : 15'(phase_gain[p]));
				write_register(CFG_TIME_STEP, (phase_step[p] < 0) ?
					15'($urandom_range(0, 32767)) : 15'(phase_step[p]));
			end else begin
				foreach (directed_rows[i])
					send_item(directed_rows[i].cmd, directed_rows[i].speed,
						directed_rows[i].pitch, directed_rows[i].rudder,
						directed_rows[i].typed, directed_rows[i].result);
			end

			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				cmd = ($urandom_range(0, 7) == 0) ? CMD_TIMEOUT : CMD_REFERENCE;

				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: spd = $urandom_range(0, 65535);
					5, 6, 7:       spd = int'($urandom_range(0, 1024)) - 512;
					default:       spd = corner[$urandom_range(0, 5)];
				endcase

				// pitch: mostly plausible targets so the estimate converges
				case ($urandom_range(0, 9))
					0, 1, 2, 3: pit = int'($urandom_range(0, 30720)) - 15360;
					4, 5: begin
						if (est_battery % 5 == 0)
							pit = 2 * est_battery / 5 - 5120;
						else
							pit = int'($urandom_range(0, 30720)) - 15360;
					end
					6, 7:    pit = $urandom_range(0, 65535);
					default: pit = corner[$urandom_range(0, 5)];
				endcase

				case ($urandom_range(0, 9))
					0, 1, 2, 3: rud = int'($urandom_range(0, 20480)) - 10240;
					4, 5:       rud = est_rudder;
					6, 7:       rud = $urandom_range(0, 65535);
					default: begin
						case ($urandom_range(0, 3))
							0: rud = 16'sd7680;
							1: rud = -16'sd7680;
							default: rud = corner[$urandom_range(0, 5)];
						endcase
					end
				endcase

				send_item(cmd, spd, pit, rud, 1'b0, '0);
			end

			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			burst_left = 0;
			drain_results();
		end

		if (fault_count == 0)
			$display("[glider_actuator_reference_to_pwm_core] OK");
		else
			$display("[glider_actuator_reference_to_pwm_core] ERROR");
		$finish;
	end

endmodule
